[rtl/ldul_pkg.sv]
// ----------------------------------------------------------------------------
// ldul_pkg
// Shared types and constants of the largest-divisor-under-limit block:
// datapath command codes, the command and status records, and fixed bounds.
// ----------------------------------------------------------------------------
package ldul_pkg;

    localparam int          DATA_W          = 32;
    localparam int          D_W             = 17;
    localparam logic [D_W-1:0]    SQRT_EDGE       = 17'd65535;
    localparam logic [DATA_W-1:0] WRAP_FOUND_EDGE = 32'hFFFF_FFF9;
    localparam logic [DATA_W-1:0] FIRST_ODD       = 32'd3;
    localparam logic [DATA_W-1:0] TWO             = 32'd2;

    localparam int OP_W = 6;
    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_NOP        = 6'd0;
    localparam t_op OP_LOAD       = 6'd1;
    localparam t_op OP_SET_L      = 6'd2;
    localparam t_op OP_RES_L      = 6'd3;
    localparam t_op OP_SET_RETRY  = 6'd4;
    localparam t_op OP_FINAL      = 6'd5;
    localparam t_op OP_OUT        = 6'd6;
    localparam t_op OP_C_INIT     = 6'd7;
    localparam t_op OP_LOWF_ST    = 6'd8;
    localparam t_op OP_GCD_INIT   = 6'd10;
    localparam t_op OP_GCD_CHK    = 6'd11;
    localparam t_op OP_GCD_W      = 6'd12;
    localparam t_op OP_NUM_RES    = 6'd13;
    localparam t_op OP_PS_CMP     = 6'd14;
    localparam t_op OP_BOUND_ST   = 6'd15;
    localparam t_op OP_BOUND_W    = 6'd16;
    localparam t_op OP_TCHK       = 6'd17;
    localparam t_op OP_FILL       = 6'd18;
    localparam t_op OP_PQ_ST      = 6'd19;
    localparam t_op OP_PQ_W       = 6'd20;
    localparam t_op OP_KN_FLD     = 6'd21;
    localparam t_op OP_KN_RD      = 6'd22;
    localparam t_op OP_KN_WR      = 6'd23;
    localparam t_op OP_KN_FIN     = 6'd24;
    localparam t_op OP_KN_MUL     = 6'd25;
    localparam t_op OP_GR_MUL     = 6'd26;
    localparam t_op OP_GR_CMP     = 6'd27;
    localparam t_op OP_C_RET      = 6'd28;
    localparam t_op OP_F_INIT     = 6'd29;
    localparam t_op OP_F_EVEN     = 6'd30;
    localparam t_op OP_F_LOOP     = 6'd31;
    localparam t_op OP_F_DIVST    = 6'd32;
    localparam t_op OP_F_DIVW     = 6'd33;
    localparam t_op OP_F_SQ       = 6'd34;
    localparam t_op OP_F_SQC      = 6'd35;
    localparam t_op OP_F_TAIL     = 6'd36;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic l_gt1;
        logic lim_gt_t;
        logic retry;
        logic div_done;
        logic rem_zero;
        logic b_zero;
        logic lowf_lt_res;
        logic more;
        logic found;
        logic bound_le_t;
        logic p_end;
        logic even;
        logic d_gt_rest;
        logic d_gt_edge;
        logic sq_gt_num;
        logic gr_ok;
        logic out_free;
    } t_status;

endpackage

[rtl/ldul_div.sv]
// ----------------------------------------------------------------------------
// ldul_div
// Shared radix-2 restoring divider: one quotient bit per cycle, then a
// one-cycle done pulse with quotient and remainder held afterwards.
// ----------------------------------------------------------------------------
module ldul_div import ldul_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvs;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DATA_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DATA_W-2:0], fits};
            r_rem <= fits ? DATA_W'(trial - {1'b0, r_dvs}) : trial[DATA_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

[rtl/ldul_datapath.sv]
// ----------------------------------------------------------------------------
// ldul_datapath
// Operand registers, factor list, the two knapsack tables, the shared divider
// and the output register. Each cycle it carries out the command it is given.
// ----------------------------------------------------------------------------
module ldul_datapath import ldul_pkg::*; #(
    parameter int TABLE_SIZE  = 1024,
    parameter int MAX_FACTORS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_st,
    input  logic [DATA_W-1:0] i_product,
    input  logic [DATA_W-1:0] i_limit,
    input  logic              i_floor_mode,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_divisor
);

    localparam int PW    = $clog2(TABLE_SIZE + 1);
    localparam int CW    = $clog2(MAX_FACTORS + 1);
    localparam int LW    = $clog2(MAX_FACTORS);
    localparam int DEPTH = TABLE_SIZE + 1;
    localparam logic [DATA_W-1:0] TSIZE = DATA_W'(TABLE_SIZE);
    localparam logic [2*DATA_W-1:0] TSIZE_X = {{DATA_W{1'b0}}, TSIZE};

    logic [DATA_W-1:0] r_prod, r_lim_in, r_lim, r_res, r_bound, r_lowf;
    logic [DATA_W-1:0] r_a, r_b, r_num, r_rest, r_f, r_fin, r_m, r_sq;
    logic              r_lower;
    logic [D_W-1:0]    r_d;
    logic [CW-1:0]     r_cnt, r_i;
    logic [PW-1:0]     r_tp, r_tq, r_tr;
    logic              r_sel;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;

    logic [DATA_W-1:0] list_mem [MAX_FACTORS];
    logic [DATA_W-1:0] r_list_q;
    logic [PW-1:0]     tab0 [DEPTH];
    logic [PW-1:0]     tab1 [DEPTH];
    logic [PW-1:0]     r_t0a, r_t0b, r_t1a, r_t1b;

    logic              div_start, div_done;
    logic [DATA_W-1:0] div_a, div_b, div_q, div_r;

    logic              push_en;
    logic [DATA_W-1:0] push_val;
    logic              retry, out_free, p_end;
    logic [PW-1:0]     cur_a, cur_b, take, kn_val, ta_addr;
    logic [2*PW-1:0]   take_full;
    logic [DATA_W-1:0] fin_sel;
    logic              we0, we1;
    logic [PW-1:0]     wdata;
    logic [2*DATA_W-1:0] res_scaled, fac_scaled;
    logic              lowf_lt_res, lowf_lt_fac;

    t_op op;
    assign op = i_cmd.op;

    ldul_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // Divider operand selection.
    always_comb begin
        div_start = 1'b0;
        div_a     = r_rest;
        div_b     = DATA_W'(r_d);
        case (op)
            OP_GCD_CHK: begin
                div_start = r_b != '0;
                div_a     = r_a;
                div_b     = r_b;
            end
            OP_BOUND_ST: begin
                div_start = 1'b1;
                div_a     = r_bound;
                div_b     = r_res;
            end
            OP_PQ_ST: begin
                div_start = 1'b1;
                div_a     = r_prod;
                div_b     = r_res;
            end
            OP_F_DIVST: begin
                div_start = 1'b1;
            end
            default: ;
        endcase
    end

    // r_lowf holds 2*limit-1; its quotient by the table size is below y exactly
    // when 2*limit-1 is below y times the table size, so no division is needed.
    assign res_scaled  = {{DATA_W{1'b0}}, r_res} * TSIZE_X;
    assign fac_scaled  = {{DATA_W{1'b0}}, r_list_q} * TSIZE_X;
    assign lowf_lt_res = {{DATA_W{1'b0}}, r_lowf} < res_scaled;
    assign lowf_lt_fac = {{DATA_W{1'b0}}, r_lowf} < fac_scaled;

    assign retry    = r_lower && (r_lim_in < r_prod) && (r_fin < r_lim_in);
    assign out_free = !r_ovalid || i_out_ready;
    assign p_end    = r_tp == r_bound[PW-1:0];
    assign cur_a    = r_sel ? r_t1a : r_t0a;
    assign cur_b    = r_sel ? r_t1b : r_t0b;
    assign take_full = r_f[PW-1:0] * cur_b;
    assign take     = take_full[PW-1:0];
    // Below the factor (quotient zero) the entry is carried over unchanged.
    assign kn_val   = (r_tq == '0) ? cur_a : ((take > cur_a) ? take : cur_a);
    assign fin_sel  = retry ? r_prod : r_fin;

    // Factor list append, saturating at the list depth.
    always_comb begin
        push_en  = 1'b0;
        push_val = r_rest;
        case (op)
            OP_F_EVEN: begin
                push_en  = r_rest != '0 && !r_rest[0];
                push_val = TWO;
            end
            OP_F_LOOP: begin
                push_en = !(DATA_W'(r_d) > r_rest) && r_d > SQRT_EDGE
                          && r_rest >= WRAP_FOUND_EDGE;
            end
            OP_F_DIVW: begin
                push_en  = div_done && div_r == '0;
                push_val = DATA_W'(r_d);
            end
            OP_F_TAIL: begin
                push_en = r_rest > 32'd1 && r_cnt != '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push_en && r_cnt < CW'(MAX_FACTORS)) begin
            list_mem[r_cnt[LW-1:0]] <= push_val;
        end
        r_list_q <= list_mem[r_i[LW-1:0]];
    end

    always_comb begin
        we0     = 1'b0;
        we1     = 1'b0;
        wdata   = kn_val;
        ta_addr = (op == OP_KN_FIN) ? r_bound[PW-1:0] : r_tp;
        if (op == OP_FILL) begin
            we0   = 1'b1;
            we1   = 1'b1;
            wdata = PW'(1);
        end else if (op == OP_KN_WR) begin
            we0 = r_sel;
            we1 = !r_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we0) begin
            tab0[r_tp] <= wdata;
        end
        if (we1) begin
            tab1[r_tp] <= wdata;
        end
        r_t0a <= tab0[ta_addr];
        r_t0b <= tab0[r_tq];
        r_t1a <= tab1[ta_addr];
        r_t1b <= tab1[r_tq];
    end

    always_ff @(posedge i_clk) begin
        if (push_en && r_cnt < CW'(MAX_FACTORS)) begin
            r_cnt <= r_cnt + 1'b1;
        end
        case (op)
            OP_LOAD: begin
                r_prod   <= i_product;
                r_lim_in <= i_limit;
                r_lower  <= i_floor_mode;
            end
            OP_SET_L:     r_lim <= r_lim_in;
            OP_RES_L:     r_fin <= r_lim_in;
            OP_SET_RETRY: r_lim <= r_lim_in + r_lim_in - 1'b1;
            OP_FINAL:     r_fin <= (r_prod < fin_sel) ? r_prod : fin_sel;
            OP_C_INIT: begin
                r_bound <= r_lim;
                r_res   <= 32'd1;
            end
            OP_LOWF_ST:   r_lowf <= r_lim + r_lim - 1'b1;
            OP_GCD_INIT: begin
                r_a <= r_prod;
                r_b <= r_lim;
            end
            OP_GCD_CHK: begin
                if (r_b == '0) begin
                    r_res <= (r_a != '0) ? r_a : 32'd1;
                end
            end
            OP_GCD_W: begin
                if (div_done) begin
                    r_a <= r_b;
                    r_b <= div_r;
                end
            end
            OP_NUM_RES: r_num <= r_res;
            OP_PS_CMP: begin
                if (lowf_lt_fac) begin
                    r_res <= r_list_q;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            OP_BOUND_W: begin
                if (div_done) begin
                    r_bound <= div_q;
                end
            end
            OP_TCHK: begin
                r_tp  <= '0;
                r_num <= r_prod;
            end
            OP_FILL: begin
                if (!p_end) begin
                    r_tp <= r_tp + 1'b1;
                end
            end
            OP_PQ_W: begin
                if (div_done) begin
                    r_num <= div_q;
                end
            end
            OP_KN_FLD: begin
                r_f  <= r_list_q;
                r_tp <= PW'(1);
                r_tq <= '0;
                r_tr <= PW'(1);
            end
            OP_KN_WR: begin
                if (p_end) begin
                    r_sel <= !r_sel;
                    r_i   <= r_i + 1'b1;
                end else begin
                    r_tp <= r_tp + 1'b1;
                    if (DATA_W'(r_tr) + 32'd1 == r_f) begin
                        r_tr <= '0;
                        r_tq <= r_tq + 1'b1;
                    end else begin
                        r_tr <= r_tr + 1'b1;
                    end
                end
            end
            OP_KN_MUL: r_res <= r_res * DATA_W'(cur_a);
            OP_GR_MUL: r_m   <= r_res * r_list_q;
            OP_GR_CMP: begin
                if (r_m <= r_lim) begin
                    r_res <= r_m;
                    r_i   <= r_i + 1'b1;
                end
            end
            OP_C_RET: r_fin <= r_res;
            OP_F_INIT: begin
                r_rest <= r_num;
                r_cnt  <= '0;
                r_d    <= D_W'(FIRST_ODD);
            end
            OP_F_EVEN: begin
                if (r_rest != '0 && !r_rest[0]) begin
                    r_rest <= r_rest >> 1;
                end
            end
            OP_F_LOOP: begin
                if (push_en) begin
                    r_rest <= 32'd1;
                end
            end
            OP_F_DIVW: begin
                if (div_done && div_r == '0) begin
                    r_rest <= div_q;
                end
            end
            OP_F_SQ:  r_sq <= DATA_W'(r_d[15:0]) * DATA_W'(r_d[15:0]);
            OP_F_SQC: begin
                if (!(r_sq > r_num)) begin
                    r_d <= r_d + D_W'(2);
                end
            end
            OP_F_TAIL: begin
                r_i   <= '0;
                r_sel <= 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (op == OP_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == OP_OUT && out_free) begin
            r_odata <= r_fin;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_divisor   = r_odata;

    assign o_st.l_gt1       = r_lim_in > 32'd1;
    assign o_st.lim_gt_t    = r_lim > TSIZE;
    assign o_st.retry       = retry;
    assign o_st.div_done    = div_done;
    assign o_st.rem_zero    = div_r == '0;
    assign o_st.b_zero      = r_b == '0;
    assign o_st.lowf_lt_res = lowf_lt_res;
    assign o_st.more        = r_i < r_cnt;
    assign o_st.found       = lowf_lt_fac;
    assign o_st.bound_le_t  = !(r_bound > TSIZE);
    assign o_st.p_end       = p_end;
    assign o_st.even        = r_rest != '0 && !r_rest[0];
    assign o_st.d_gt_rest   = DATA_W'(r_d) > r_rest;
    assign o_st.d_gt_edge   = r_d > SQRT_EDGE;
    assign o_st.sq_gt_num   = r_sq > r_num;
    assign o_st.gr_ok       = !(r_m > r_lim);
    assign o_st.out_free    = out_free;

endmodule

[rtl/ldul_ctrl.sv]
// ----------------------------------------------------------------------------
// ldul_ctrl
// Sequencer: walks the search (pre-factor, knapsack or greedy, retry, clip)
// and the shared factorizing routine, issuing one command per cycle.
// ----------------------------------------------------------------------------
module ldul_ctrl import ldul_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_DISP  = 6'd1;
    localparam logic [5:0] S_POST1 = 6'd2;
    localparam logic [5:0] S_FINAL = 6'd3;
    localparam logic [5:0] S_OUT   = 6'd4;
    localparam logic [5:0] S_CSTART= 6'd5;
    localparam logic [5:0] S_LOWF  = 6'd6;
    localparam logic [5:0] S_GINIT = 6'd8;
    localparam logic [5:0] S_GCHK  = 6'd9;
    localparam logic [5:0] S_GW    = 6'd10;
    localparam logic [5:0] S_GCMP  = 6'd11;
    localparam logic [5:0] S_PSRD  = 6'd12;
    localparam logic [5:0] S_PSCMP = 6'd13;
    localparam logic [5:0] S_BND   = 6'd14;
    localparam logic [5:0] S_BNDW  = 6'd15;
    localparam logic [5:0] S_TCHK  = 6'd16;
    localparam logic [5:0] S_FILL  = 6'd17;
    localparam logic [5:0] S_PQ    = 6'd18;
    localparam logic [5:0] S_PQW   = 6'd19;
    localparam logic [5:0] S_KFRD  = 6'd20;
    localparam logic [5:0] S_KFLD  = 6'd21;
    localparam logic [5:0] S_KRD   = 6'd22;
    localparam logic [5:0] S_KWR   = 6'd23;
    localparam logic [5:0] S_KFIN  = 6'd24;
    localparam logic [5:0] S_KMUL  = 6'd25;
    localparam logic [5:0] S_GRRD  = 6'd26;
    localparam logic [5:0] S_GRMUL = 6'd27;
    localparam logic [5:0] S_GRCMP = 6'd28;
    localparam logic [5:0] S_CRET  = 6'd29;
    localparam logic [5:0] S_FINIT = 6'd30;
    localparam logic [5:0] S_FEVEN = 6'd31;
    localparam logic [5:0] S_FLOOP = 6'd32;
    localparam logic [5:0] S_FDST  = 6'd33;
    localparam logic [5:0] S_FDW   = 6'd34;
    localparam logic [5:0] S_FSQ   = 6'd35;
    localparam logic [5:0] S_FSQC  = 6'd36;
    localparam logic [5:0] S_FTAIL = 6'd37;

    // Where the factorizing routine returns to.
    localparam logic [1:0] RET_SCAN   = 2'd0;
    localparam logic [1:0] RET_KNAP   = 2'd1;
    localparam logic [1:0] RET_GREEDY = 2'd2;

    logic [5:0] r_state, n_state;
    logic [1:0] r_fret, n_fret;
    logic       r_pass, n_pass;
    t_op        op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fret  <= RET_SCAN;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fret  <= n_fret;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fret  = r_fret;
        n_pass  = r_pass;
        op      = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_st.l_gt1) begin
                    op      = OP_SET_L;
                    n_pass  = 1'b0;
                    n_state = S_CSTART;
                end else begin
                    op      = OP_RES_L;
                    n_state = S_POST1;
                end
            end
            S_POST1: begin
                if (i_st.retry) begin
                    op      = OP_SET_RETRY;
                    n_pass  = 1'b1;
                    n_state = S_CSTART;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                op      = OP_FINAL;
                n_state = S_OUT;
            end
            S_OUT: begin
                op = OP_OUT;
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CSTART: begin
                op      = OP_C_INIT;
                n_state = i_st.lim_gt_t ? S_LOWF : S_TCHK;
            end
            S_LOWF: begin
                op      = OP_LOWF_ST;
                n_state = S_GINIT;
            end
            S_GINIT: begin
                op      = OP_GCD_INIT;
                n_state = S_GCHK;
            end
            S_GCHK: begin
                op      = OP_GCD_CHK;
                n_state = i_st.b_zero ? S_GCMP : S_GW;
            end
            S_GW: begin
                op = OP_GCD_W;
                if (i_st.div_done) begin
                    n_state = S_GCHK;
                end
            end
            S_GCMP: begin
                op = OP_NUM_RES;
                if (i_st.lowf_lt_res) begin
                    n_fret  = RET_SCAN;
                    n_state = S_FINIT;
                end else begin
                    n_state = S_BND;
                end
            end
            S_PSRD: begin
                n_state = i_st.more ? S_PSCMP : S_BND;
            end
            S_PSCMP: begin
                op      = OP_PS_CMP;
                n_state = i_st.found ? S_BND : S_PSRD;
            end
            S_BND: begin
                op      = OP_BOUND_ST;
                n_state = S_BNDW;
            end
            S_BNDW: begin
                op = OP_BOUND_W;
                if (i_st.div_done) begin
                    n_state = S_TCHK;
                end
            end
            S_TCHK: begin
                op = OP_TCHK;
                if (i_st.bound_le_t) begin
                    n_state = S_FILL;
                end else begin
                    n_fret  = RET_GREEDY;
                    n_state = S_FINIT;
                end
            end
            S_FILL: begin
                op = OP_FILL;
                if (i_st.p_end) begin
                    n_state = S_PQ;
                end
            end
            S_PQ: begin
                op      = OP_PQ_ST;
                n_state = S_PQW;
            end
            S_PQW: begin
                op = OP_PQ_W;
                if (i_st.div_done) begin
                    n_fret  = RET_KNAP;
                    n_state = S_FINIT;
                end
            end
            S_KFRD: begin
                n_state = i_st.more ? S_KFLD : S_KFIN;
            end
            S_KFLD: begin
                op      = OP_KN_FLD;
                n_state = S_KRD;
            end
            S_KRD: begin
                op      = OP_KN_RD;
                n_state = S_KWR;
            end
            S_KWR: begin
                op      = OP_KN_WR;
                n_state = i_st.p_end ? S_KFRD : S_KRD;
            end
            S_KFIN: begin
                op      = OP_KN_FIN;
                n_state = S_KMUL;
            end
            S_KMUL: begin
                op      = OP_KN_MUL;
                n_state = S_CRET;
            end
            S_GRRD: begin
                n_state = i_st.more ? S_GRMUL : S_CRET;
            end
            S_GRMUL: begin
                op      = OP_GR_MUL;
                n_state = S_GRCMP;
            end
            S_GRCMP: begin
                op      = OP_GR_CMP;
                n_state = i_st.gr_ok ? S_GRRD : S_CRET;
            end
            S_CRET: begin
                op      = OP_C_RET;
                n_state = r_pass ? S_FINAL : S_POST1;
            end
            S_FINIT: begin
                op      = OP_F_INIT;
                n_state = S_FEVEN;
            end
            S_FEVEN: begin
                op = OP_F_EVEN;
                if (!i_st.even) begin
                    n_state = S_FLOOP;
                end
            end
            S_FLOOP: begin
                op      = OP_F_LOOP;
                n_state = (i_st.d_gt_rest || i_st.d_gt_edge) ? S_FTAIL : S_FDST;
            end
            S_FDST: begin
                op      = OP_F_DIVST;
                n_state = S_FDW;
            end
            S_FDW: begin
                op = OP_F_DIVW;
                if (i_st.div_done) begin
                    n_state = i_st.rem_zero ? S_FDST : S_FSQ;
                end
            end
            S_FSQ: begin
                op      = OP_F_SQ;
                n_state = S_FSQC;
            end
            S_FSQC: begin
                op      = OP_F_SQC;
                n_state = i_st.sq_gt_num ? S_FTAIL : S_FLOOP;
            end
            S_FTAIL: begin
                op = OP_F_TAIL;
                case (r_fret)
                    RET_SCAN: n_state = S_PSRD;
                    RET_KNAP: n_state = S_KFRD;
                    default:  n_state = S_GRRD;
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd.op   = op;
    assign o_in_ready = r_state == S_IDLE;

endmodule

[rtl/largest_divisor_under_limit_top.sv]
// ----------------------------------------------------------------------------
// largest_divisor_under_limit_top
// Finds a divisor of a product near a limit by trial-division factoring and a
// multiplicative 0/1 knapsack, with a gcd pre-factor and a greedy fallback.
//
//   Channel   Dir  tdata  tuser  Contents
//   s_axis    in   64     1      product, limit; tuser: floor_mode
//   m_axis    out  32     -      divisor
//
// One item is in work at a time. Factoring dominates: each odd trial divisor
// waits on the shared radix-2 divider, and an item runs up to four
// factorizations when the gcd pre-factor and the lower-mode retry both
// occur. The knapsack reads and writes each table entry up to the bound
// once per factor.
// Reset is synchronous and active low; no clearing pass is needed.
// A new item is taken while the previous result still waits in the output
// register; a stalled output holds the sequencer only at its last step.
// ----------------------------------------------------------------------------
module largest_divisor_under_limit_top import ldul_pkg::*; #(
    parameter int TABLE_SIZE  = 1024,
    parameter int MAX_FACTORS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] product, [63:32] limit
    input  logic [0:0]  s_axis_tuser,   // [0] floor_mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] divisor
);

    t_cmd    cmd;
    t_status st;

    ldul_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    ldul_datapath #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_FACTORS (MAX_FACTORS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_product    (s_axis_tdata[31:0]),
        .i_limit      (s_axis_tdata[63:32]),
        .i_floor_mode (s_axis_tuser[0]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_divisor    (m_axis_tdata)
    );

endmodule

[sim/tb_largest_divisor_under_limit_top.sv]
// ----------------------------------------------------------------------------
// tb_largest_divisor_under_limit_top
// Self-checking testbench for the largest-divisor-under-limit block. A
// scoreboard recomputes the divisor for every accepted input transfer and
// compares it with each output transfer in order. A short directed set covers
// the corner cases. Random items built from small primes follow, with bursty
// input traffic, a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_largest_divisor_under_limit_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_N      = 1024;
    localparam int FACTOR_CAP   = 32;
    localparam int RANDOM_ITEMS = 100;
    localparam int IDLE_LIMIT   = 25000000;
    localparam int HOLD_CYCLES  = 150000;

    class divisor_scoreboard;
        logic [31:0] expected_q[$];
        logic [31:0] factors[$];
        logic [31:0] tbl[2][TABLE_N+1];
        int          errors;

        function logic [31:0] gcd_of(logic [31:0] a, logic [31:0] b);
            logic [31:0] r;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return (a != 0) ? a : 32'd1;
        endfunction

        function void add_factor(logic [31:0] v);
            if (factors.size() < FACTOR_CAP) factors.push_back(v);
        endfunction

        // Trial division, including the behavior of an empty list for most primes.
        function void factor_value(logic [31:0] num);
            logic [31:0] rest;
            logic [31:0] d;
            factors.delete();
            rest = num;
            if (rest > 0) begin
                while (rest[0] == 1'b0) begin
                    add_factor(32'd2);
                    rest = rest >> 1;
                end
            end
            d = 32'd3;
            while (d <= rest) begin
                if (d > 32'd65535) begin
                    if (rest >= 32'hFFFF_FFF9) begin
                        add_factor(rest);
                        rest = 32'd1;
                    end
                    break;
                end
                while (rest % d == 0) begin
                    add_factor(d);
                    rest = rest / d;
                end
                if (64'(d) * 64'(d) > 64'(num)) break;
                d = d + 32'd2;
            end
            if (rest > 1 && factors.size() != 0) add_factor(rest);
        endfunction

        function logic [31:0] search(logic [31:0] product, logic [31:0] limit);
            logic [31:0] bound;
            logic [31:0] res;
            logic [31:0] lowf;
            logic [31:0] g;
            logic [31:0] f;
            logic [31:0] keep;
            logic [31:0] take;
            int          cur;
            bound = limit;
            res   = 32'd1;
            if (limit > TABLE_N) begin
                lowf = (limit + limit - 32'd1) / TABLE_N;
                g    = gcd_of(product, limit);
                res  = g;
                if (lowf < g) begin
                    factor_value(res);
                    foreach (factors[i]) begin
                        if (lowf < factors[i]) begin
                            res = factors[i];
                            break;
                        end
                    end
                end
                bound = bound / res;
            end
            if (bound <= TABLE_N) begin
                cur = 0;
                for (int p = 0; p <= bound; p++) tbl[0][p] = 32'd1;
                tbl[1][0] = 32'd1;
                factor_value(product / res);
                foreach (factors[i]) begin
                    f = factors[i];
                    for (int p = 1; p <= bound; p++) begin
                        keep = tbl[cur][p];
                        if (p < f) begin
                            tbl[1-cur][p] = keep;
                        end else begin
                            take = f * tbl[cur][p / f];
                            tbl[1-cur][p] = (take > keep) ? take : keep;
                        end
                    end
                    cur = 1 - cur;
                end
                res = res * tbl[cur][bound];
            end else begin
                factor_value(product);
                foreach (factors[i]) begin
                    f = res * factors[i];
                    if (f <= limit) res = f;
                    else break;
                end
            end
            return res;
        endfunction

        function void note_input(logic [31:0] product, logic [31:0] limit, logic floor_mode);
            logic [31:0] res;
            res = (limit > 1) ? search(product, limit) : limit;
            if (floor_mode && limit < product) begin
                if (res < limit) res = search(product, limit + limit - 32'd1);
                if (res < limit) res = product;
            end
            if (product < res) res = product;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [31:0] divisor);
            logic [31:0] want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output transfer: divisor=%0d", divisor);
                return;
            end
            want = expected_q.pop_front();
            if (divisor !== want) begin
                errors++;
                if (errors <= 10)
                    $display("divisor mismatch: expected %0d, got %0d", want, divisor);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] product, [63:32] limit
    logic [0:0]  s_axis_tuser;   // [0] floor_mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] divisor

    divisor_scoreboard sb;
    logic [64:0]       stim_q[$];
    bit                random_phase;
    int                idle_cycles;

    largest_divisor_under_limit_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Scoreboard hooks and the watchdog sample at the edge, before the updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver: a patterned stall, plus one long hold-off once random traffic starts.
    initial begin
        int cyc;
        cyc = 0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        wait (random_phase);
        @(posedge i_clk);
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cyc++;
            if ((cyc / 64) % 3 == 0) m_axis_tready <= 1'b1;
            else m_axis_tready <= ((cyc % 5) != 0) && ($urandom_range(0, 3) != 0);
        end
    end

    // Before the random phase the receiver still has to drain directed results.
    initial begin
        wait (i_rst_n);
        while (!random_phase) begin
            @(posedge i_clk);
            if (!random_phase) m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    function automatic logic [31:0] smooth_product();
        logic [31:0] primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                                    47, 53, 59, 61, 67, 71, 97, 101, 251, 509, 1021};
        logic [63:0] acc;
        logic [63:0] next;
        int          count;
        if ($urandom_range(0, 9) == 0) return 32'($urandom_range(0, 5000));
        acc   = 1;
        count = $urandom_range(1, 14);
        for (int k = 0; k < count; k++) begin
            next = acc * primes[$urandom_range(0, 24)];
            if (next < 64'h1_0000_0000) acc = next;
        end
        return acc[31:0];
    endfunction

    // The flag sits above the data word: {tuser, tdata}.
    function automatic logic [64:0] pack_item(logic [31:0] product, logic [31:0] limit,
                                              logic floor_mode);
        return {floor_mode, limit, product};
    endfunction

    task automatic send_all();
        int burst;
        while (stim_q.size() != 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && stim_q.size() != 0) begin
                {s_axis_tuser, s_axis_tdata} <= stim_q.pop_front();
                s_axis_tvalid <= 1'b1;
                do @(posedge i_clk); while (!s_axis_tready);
                burst--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        logic [31:0] product;
        logic [31:0] limit;
        int          waited;
        sb            = new();
        random_phase  = 1'b0;
        idle_cycles   = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero product, fast path limits, tiny primes, wrap cases, greedy and pre-factor paths.
        stim_q.push_back(pack_item(32'd0, 32'd0, 1'b0));
        stim_q.push_back(pack_item(32'd0, 32'd5, 1'b1));
        stim_q.push_back(pack_item(32'd12, 32'd0, 1'b1));
        stim_q.push_back(pack_item(32'd12, 32'd1, 1'b1));
        stim_q.push_back(pack_item(32'd1, 32'd1, 1'b0));
        stim_q.push_back(pack_item(32'd2, 32'd7, 1'b0));
        stim_q.push_back(pack_item(32'd3, 32'd2, 1'b1));
        stim_q.push_back(pack_item(32'd1009, 32'd10, 1'b0));
        stim_q.push_back(pack_item(32'd1009, 32'd10, 1'b1));
        stim_q.push_back(pack_item(32'hFFFF_FFFE, 32'd100, 1'b0));
        stim_q.push_back(pack_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1));
        stim_q.push_back(pack_item(32'hFFFF_FFFE, 32'h8000_0001, 1'b1));
        stim_q.push_back(pack_item(32'h8000_0000, 32'h8000_0000, 1'b1));
        stim_q.push_back(pack_item(32'h8000_0000, 32'd3000, 1'b1));
        stim_q.push_back(pack_item(32'd720720, 32'd1024, 1'b0));
        stim_q.push_back(pack_item(32'd720720, 32'd1025, 1'b1));
        stim_q.push_back(pack_item(32'd720720, 32'd5000, 1'b1));
        stim_q.push_back(pack_item(32'd720720, 32'd700000, 1'b0));
        stim_q.push_back(pack_item(32'hC000_0000, 32'h7FFF_FFFF, 1'b1));
        stim_q.push_back(pack_item(32'hFFFF_FFFB, 32'd2, 1'b0));
        send_all();
        while (sb.expected_q.size() != 0) @(posedge i_clk);

        random_phase = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            product = smooth_product();
            case ($urandom_range(0, 3))
                0:       limit = $urandom_range(0, 1100);
                1:       limit = product >> $urandom_range(0, 12);
                2:       limit = $urandom();
                default: limit = $urandom_range(0, 3);
            endcase
            stim_q.push_back(pack_item(product, limit, 1'($urandom_range(0, 1))));
        end
        send_all();

        waited = 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        while (waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[largest_divisor_under_limit_top.f]
rtl/ldul_pkg.sv
rtl/ldul_div.sv
rtl/ldul_datapath.sv
rtl/ldul_ctrl.sv
rtl/largest_divisor_under_limit_top.sv
sim/tb_largest_divisor_under_limit_top.sv
